@@ rtl/rmth_pkg.sv @@
// Shared types for the running median two-heap unit.
`timescale 1ns / 1ps
`default_nettype none
package rmth_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_NEXT,
    ST_PUSH_CHK,
    ST_PUSH_CMP,
    ST_POP_LAST,
    ST_POP_CHK,
    ST_POP_C0,
    ST_POP_C1,
    ST_POP_CMP,
    ST_FINISH
  } rmth_state_t;

  // Heap operation still to run for the current item
  typedef enum logic [1:0] {
    PH_POP,
    PH_PUSHMV,
    PH_PUSHX,
    PH_DONE
  } rmth_phase_t;

  // Heap select codes
  localparam logic HEAP_LO = 1'b0;
  localparam logic HEAP_HI = 1'b1;

endpackage
`default_nettype wire

@@ rtl/rmth_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rmth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/running_median_two_heaps_unit.sv @@
// Top level: running median over a max-heap and a min-heap held in RAM.
//
//  channel | ports                        | direction | payload
//  --------+------------------------------+-----------+---------------------------
//  input   | in_valid / in_ready          | in        | in_value (s32)
//  result  | out_valid / out_ready        | out       | out_median (s32), out_dropped
//
// An item that is dropped does no heap work; otherwise a pop's sift-down reads and
// compares both children at each level (POP_CHK, POP_C0, POP_C1, POP_CMP) and each
// push's sift-up reads and compares the parent (PUSH_CHK, PUSH_CMP), all through one
// comparator and one write and one read RAM port per heap. Synchronous active-low
// reset clears counts, median and control; heap RAM contents are never cleared. A
// result waiting on out_ready holds the sequencer in its last step, but the next
// item is taken as soon as that result moves into the output register.
`timescale 1ns / 1ps
`default_nettype none
module running_median_two_heaps_unit
  import rmth_pkg::*;
#(
  parameter int HALF_CAPACITY = 512
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_median,
  output logic                    out_dropped
);

  localparam int CW = $clog2(HALF_CAPACITY + 1);
  localparam int IW = $clog2(HALF_CAPACITY);
  localparam int EW = IW + 2;

  rmth_state_t state_r, state_nxt;
  rmth_phase_t phase_r, phase_nxt;

  logic               sel_r, sel_nxt;
  logic               mvh_r, mvh_nxt;
  logic               xh_r, xh_nxt;
  logic               eq_r, eq_nxt;
  logic               drop_r, drop_nxt;
  logic               bsel_r, bsel_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic signed [31:0] mvval_r, mvval_nxt;
  logic signed [31:0] v_r, v_nxt;
  logic signed [31:0] best_r, best_nxt;
  logic signed [31:0] top_lo_r, top_lo_nxt;
  logic signed [31:0] top_hi_r, top_hi_nxt;
  logic signed [31:0] med_r, med_nxt;
  logic [IW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [CW-1:0]      cnt_lo_r, cnt_lo_nxt;
  logic [CW-1:0]      cnt_hi_r, cnt_hi_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_median_r, out_median_nxt;
  logic               out_dropped_r, out_dropped_nxt;

  // RAM controls
  logic               we_lo, we_hi, wr_en;
  logic [IW-1:0]      waddr, raddr;
  logic signed [31:0] wdata;
  logic signed [31:0] rd_lo, rd_hi, rdata;

  // Shared compare unit and index helpers
  logic signed [31:0] cmp_a, cmp_b;
  logic               above;
  logic [EW-1:0]      c_w, c1_w, n_ext;
  logic [IW-1:0]      p_w;
  logic [CW-1:0]      cnt_mvh, cnt_nmvh, cnt_xh;
  logic               goes_low, full;
  logic signed [32:0] sum_w, sum_adj;
  logic signed [31:0] mean_w, fin_med;

  assign rdata    = sel_r ? rd_hi : rd_lo;
  assign c_w      = {1'b0, i_r, 1'b1};
  assign c1_w     = c_w + EW'(1);
  assign n_ext    = EW'(n_r);
  assign p_w      = (i_r - IW'(1)) >> 1;
  assign cnt_mvh  = mvh_r ? cnt_hi_r : cnt_lo_r;
  assign cnt_nmvh = mvh_r ? cnt_lo_r : cnt_hi_r;
  assign cnt_xh   = xh_r ? cnt_hi_r : cnt_lo_r;
  assign goes_low = x_r < med_r;
  assign full     = (cnt_lo_r == CW'(HALF_CAPACITY)) && (cnt_hi_r == CW'(HALF_CAPACITY));

  // Pick compare operands per step
  always_comb begin
    cmp_a = v_r;
    cmp_b = rdata;
    case (state_r)
      ST_POP_C1: begin
        cmp_a = rdata;
        cmp_b = best_r;
      end
      ST_POP_CMP: begin
        cmp_a = best_r;
        cmp_b = v_r;
      end
      default: begin
        cmp_a = v_r;
        cmp_b = rdata;
      end
    endcase
  end

  // Max order for the lower heap, min order for the upper heap
  assign above = (sel_r == HEAP_LO) ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

  // Mean of both tops, truncated toward zero
  assign sum_w   = {top_lo_r[31], top_lo_r} + {top_hi_r[31], top_hi_r};
  assign sum_adj = sum_w + {32'd0, sum_w[32] & sum_w[0]};
  assign mean_w  = sum_adj[32:1];
  assign fin_med = drop_r ? med_r : (eq_r ? (xh_r ? top_hi_r : top_lo_r) : mean_w);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_DECIDE;
      ST_DECIDE:   state_nxt = ST_NEXT;
      ST_NEXT: begin
        unique case (phase_r)
          PH_POP:    state_nxt = (cnt_mvh == CW'(1)) ? ST_NEXT : ST_POP_LAST;
          PH_PUSHMV: state_nxt = ST_PUSH_CHK;
          PH_PUSHX:  state_nxt = ST_PUSH_CHK;
          PH_DONE:   state_nxt = ST_FINISH;
          default:   state_nxt = ST_FINISH;
        endcase
      end
      ST_PUSH_CHK: state_nxt = (i_r == '0) ? ST_NEXT : ST_PUSH_CMP;
      ST_PUSH_CMP: state_nxt = above ? ST_PUSH_CHK : ST_NEXT;
      ST_POP_LAST: state_nxt = ST_POP_CHK;
      ST_POP_CHK:  state_nxt = (c_w >= n_ext) ? ST_NEXT : ST_POP_C0;
      ST_POP_C0:   state_nxt = (c1_w < n_ext) ? ST_POP_C1 : ST_POP_CMP;
      ST_POP_C1:   state_nxt = ST_POP_CMP;
      ST_POP_CMP:  state_nxt = above ? ST_POP_CHK : ST_NEXT;
      ST_FINISH:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: handshake and RAM access
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    wr_en    = 1'b0;
    waddr    = i_r;
    wdata    = v_r;
    raddr    = IW'(c_w);
    unique case (state_r)
      ST_NEXT:     raddr = IW'(cnt_mvh - CW'(1));
      ST_PUSH_CHK: begin
        raddr = p_w;
        if (i_r == '0) wr_en = 1'b1;
      end
      ST_PUSH_CMP: begin
        wr_en = 1'b1;
        if (above) wdata = rdata;
      end
      ST_POP_CHK:  if (c_w >= n_ext) wr_en = 1'b1;
      ST_POP_C0:   raddr = IW'(c1_w);
      ST_POP_CMP: begin
        wr_en = 1'b1;
        if (above) wdata = best_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign we_lo = wr_en && (sel_r == HEAP_LO);
  assign we_hi = wr_en && (sel_r == HEAP_HI);

  // Datapath next values
  always_comb begin
    phase_nxt       = phase_r;
    sel_nxt         = sel_r;
    mvh_nxt         = mvh_r;
    xh_nxt          = xh_r;
    eq_nxt          = eq_r;
    drop_nxt        = drop_r;
    bsel_nxt        = bsel_r;
    x_nxt           = x_r;
    mvval_nxt       = mvval_r;
    v_nxt           = v_r;
    best_nxt        = best_r;
    top_lo_nxt      = top_lo_r;
    top_hi_nxt      = top_hi_r;
    med_nxt         = med_r;
    i_nxt           = i_r;
    n_nxt           = n_r;
    cnt_lo_nxt      = cnt_lo_r;
    cnt_hi_nxt      = cnt_hi_r;
    out_valid_nxt   = out_valid_r;
    out_median_nxt  = out_median_r;
    out_dropped_nxt = out_dropped_r;

    // Drop the result once taken
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    // Track heap tops on writes to the root
    if (wr_en && (waddr == '0)) begin
      if (sel_r == HEAP_LO) top_lo_nxt = wdata;
      else top_hi_nxt = wdata;
    end

    case (state_r)
      ST_IDLE: if (in_valid) x_nxt = in_value;
      ST_DECIDE: begin
        drop_nxt  = full;
        eq_nxt    = (cnt_lo_r == cnt_hi_r);
        xh_nxt    = !goes_low;
        mvh_nxt   = (cnt_lo_r < cnt_hi_r) ? HEAP_HI : HEAP_LO;
        mvval_nxt = (cnt_lo_r < cnt_hi_r) ? top_hi_r : top_lo_r;
        if (full) begin
          phase_nxt = PH_DONE;
        end else if (cnt_lo_r == cnt_hi_r) begin
          phase_nxt = PH_PUSHX;
        end else if ((cnt_lo_r < cnt_hi_r) ? !goes_low : goes_low) begin
          phase_nxt = PH_POP;
        end else begin
          phase_nxt = PH_PUSHX;
        end
      end
      ST_NEXT: begin
        case (phase_r)
          PH_POP: begin
            sel_nxt   = mvh_r;
            n_nxt     = cnt_mvh - CW'(1);
            phase_nxt = PH_PUSHMV;
            if (mvh_r) cnt_hi_nxt = cnt_hi_r - CW'(1);
            else cnt_lo_nxt = cnt_lo_r - CW'(1);
          end
          PH_PUSHMV: begin
            sel_nxt   = !mvh_r;
            v_nxt     = mvval_r;
            i_nxt     = IW'(cnt_nmvh);
            phase_nxt = PH_PUSHX;
            if (mvh_r) cnt_lo_nxt = cnt_lo_r + CW'(1);
            else cnt_hi_nxt = cnt_hi_r + CW'(1);
          end
          PH_PUSHX: begin
            sel_nxt   = xh_r;
            v_nxt     = x_r;
            i_nxt     = IW'(cnt_xh);
            phase_nxt = PH_DONE;
            if (xh_r) cnt_hi_nxt = cnt_hi_r + CW'(1);
            else cnt_lo_nxt = cnt_lo_r + CW'(1);
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
      end
      ST_PUSH_CMP: if (above) i_nxt = p_w;
      ST_POP_LAST: begin
        v_nxt = rdata;
        i_nxt = '0;
      end
      ST_POP_C0: begin
        best_nxt = rdata;
        bsel_nxt = 1'b0;
      end
      ST_POP_C1: begin
        if (above) begin
          best_nxt = rdata;
          bsel_nxt = 1'b1;
        end
      end
      ST_POP_CMP: if (above) i_nxt = bsel_r ? IW'(c1_w) : IW'(c_w);
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          med_nxt         = fin_med;
          out_valid_nxt   = 1'b1;
          out_median_nxt  = fin_med;
          out_dropped_nxt = drop_r;
        end
      end
      default: begin
        best_nxt = best_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_DONE;
      cnt_lo_r    <= '0;
      cnt_hi_r    <= '0;
      med_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_lo_r    <= cnt_lo_nxt;
      cnt_hi_r    <= cnt_hi_nxt;
      med_r       <= med_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sel_r         <= sel_nxt;
    mvh_r         <= mvh_nxt;
    xh_r          <= xh_nxt;
    eq_r          <= eq_nxt;
    drop_r        <= drop_nxt;
    bsel_r        <= bsel_nxt;
    x_r           <= x_nxt;
    mvval_r       <= mvval_nxt;
    v_r           <= v_nxt;
    best_r        <= best_nxt;
    top_lo_r      <= top_lo_nxt;
    top_hi_r      <= top_hi_nxt;
    i_r           <= i_nxt;
    n_r           <= n_nxt;
    out_median_r  <= out_median_nxt;
    out_dropped_r <= out_dropped_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_median  = out_median_r;
  assign out_dropped = out_dropped_r;

  // Lower half, max-ordered
  rmth_ram #(
    .WIDTH(32),
    .DEPTH(HALF_CAPACITY)
  ) u_lo_ram (
    .clk  (clk),
    .we   (we_lo),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_lo)
  );

  // Upper half, min-ordered
  rmth_ram #(
    .WIDTH(32),
    .DEPTH(HALF_CAPACITY)
  ) u_hi_ram (
    .clk  (clk),
    .we   (we_hi),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_hi)
  );

endmodule
`default_nettype wire

@@ sim/running_median_two_heaps_unit_test.sv @@
// Self-checking testbench for the two-heap running median unit.
`timescale 1ns / 1ps
module running_median_two_heaps_unit_test;
  import rmth_pkg::*;

  localparam int HALF_CAP   = 512;
  localparam int N_RANDOM   = 1450;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 600;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic              typed;
    logic signed [31:0] median;
    logic              dropped;
  } median_t;

  typedef struct {
    logic signed [31:0] value;
    logic              typed;
    logic signed [31:0] median;
    logic              dropped;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [31:0] in_value = '0;
  logic out_ready = 1'b0;
  wire in_ready, out_valid, out_dropped;
  wire signed [31:0] out_median;

  running_median_two_heaps_unit #(.HALF_CAPACITY(HALF_CAP)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_median(out_median), .out_dropped(out_dropped)
  );

  always #5 clk = ~clk;

  // Predictor state: lower half max-heap, upper half min-heap
  int lo_heap [HALF_CAP];
  int hi_heap [HALF_CAP];
  int lo_cnt = 0;
  int hi_cnt = 0;
  int run_median = 0;

  median_t typed_q [$];
  median_t median_q [$];
  int  n_accepted = 0;
  int  errors = 0;
  int  idle_cycles = 0;
  bit  stim_done = 1'b0;
  bit  hold_done = 1'b0;

  function automatic bit sits_above(int a, int b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  function automatic void heap_insert(ref int h [HALF_CAP], ref int cnt, input int v,
                                      input bit is_max);
    int i;
    int p;
    i = cnt;
    cnt++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!sits_above(v, h[p], is_max)) break;
      h[i] = h[p];
      i = p;
    end
    h[i] = v;
  endfunction

  function automatic void heap_remove_top(ref int h [HALF_CAP], ref int cnt,
                                          input bit is_max);
    int n;
    int i;
    int c;
    int v;
    n = cnt - 1;
    cnt = n;
    if (n == 0) return;
    v = h[n];
    i = 0;
    forever begin
      c = 2 * i + 1;
      if (c >= n) break;
      if (c + 1 < n && sits_above(h[c + 1], h[c], is_max)) c++;
      if (!sits_above(h[c], v, is_max)) break;
      h[i] = h[c];
      i = c;
    end
    h[i] = v;
  endfunction

  function automatic int mean_of_tops();
    longint s;
    s = longint'(lo_heap[0]) + longint'(hi_heap[0]);
    return int'(s / 2);
  endfunction

  // Insert one value and return the new median and drop flag
  function automatic median_t predict_median(int x);
    median_t r;
    int t;
    bit goes_low;
    goes_low = x < run_median;
    r.typed = 1'b0;
    r.dropped = 1'b0;
    if (lo_cnt >= HALF_CAP && hi_cnt >= HALF_CAP) begin
      r.dropped = 1'b1;
    end else if (lo_cnt < hi_cnt) begin
      if (!goes_low) begin
        t = hi_heap[0];
        heap_remove_top(hi_heap, hi_cnt, 1'b0);
        heap_insert(lo_heap, lo_cnt, t, 1'b1);
        heap_insert(hi_heap, hi_cnt, x, 1'b0);
      end else begin
        heap_insert(lo_heap, lo_cnt, x, 1'b1);
      end
      run_median = mean_of_tops();
    end else if (lo_cnt == hi_cnt) begin
      if (goes_low) begin
        heap_insert(lo_heap, lo_cnt, x, 1'b1);
        run_median = lo_heap[0];
      end else begin
        heap_insert(hi_heap, hi_cnt, x, 1'b0);
        run_median = hi_heap[0];
      end
    end else begin
      if (goes_low) begin
        t = lo_heap[0];
        heap_remove_top(lo_heap, lo_cnt, 1'b1);
        heap_insert(hi_heap, hi_cnt, t, 1'b0);
        heap_insert(lo_heap, lo_cnt, x, 1'b1);
      end else begin
        heap_insert(hi_heap, hi_cnt, x, 1'b0);
      end
      run_median = mean_of_tops();
    end
    r.median = run_median;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return $signed($urandom_range(0, 40)) - 20;
      7: return $urandom_range(0, 1) ? S32_MAX - $urandom_range(0, 2)
                                     : S32_MIN + $urandom_range(0, 2);
      8: return run_median + $signed($urandom_range(0, 6)) - 3;
      default: return $signed($urandom_range(0, 1000)) - 500;
    endcase
  endfunction

  // Directed rows: first value sets the median, extremes average to zero
  row_t rows [] = '{
    '{S32_MIN, 1'b1, S32_MIN, 1'b0},
    '{S32_MAX, 1'b1, 32'sd0,  1'b0},
    '{S32_MAX, 1'b0, 32'sd0,  1'b0},
    '{S32_MIN, 1'b0, 32'sd0,  1'b0},
    '{32'sd0,  1'b0, 32'sd0,  1'b0},
    '{32'sd0,  1'b0, 32'sd0,  1'b0},
    '{-32'sd1, 1'b0, 32'sd0,  1'b0},
    '{32'sd1,  1'b0, 32'sd0,  1'b0},
    '{32'sd5,  1'b0, 32'sd0,  1'b0},
    '{32'sd5,  1'b0, 32'sd0,  1'b0},
    '{32'sd5,  1'b0, 32'sd0,  1'b0},
    '{-32'sd7, 1'b0, 32'sd0,  1'b0},
    '{-32'sd7, 1'b0, 32'sd0,  1'b0},
    '{-32'sd3, 1'b0, 32'sd0,  1'b0},
    '{32'sd3,  1'b0, 32'sd0,  1'b0},
    '{32'h5555_5555, 1'b0, 32'sd0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 32'sd0, 1'b0}
  };

  task automatic send_item(logic signed [31:0] v, median_t tag);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_q.push_back(tag);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender
  initial begin
    median_t tag;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      tag.typed = rows[i].typed;
      tag.median = rows[i].median;
      tag.dropped = rows[i].dropped;
      send_item(rows[i].value, tag);
    end
    tag.typed = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) send_item(pick_value(), tag);
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, one long hold-off to back up the input
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (!hold_done && n_accepted >= 300) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_done = 1'b1;
      end
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Predict on input items, check result items, watch for a hang
  always @(posedge clk) begin
    median_t exp_r;
    median_t tag;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && in_ready) begin
        n_accepted <= n_accepted + 1;
        tag = typed_q.pop_front();
        exp_r = predict_median(in_value);
        if (tag.typed) exp_r = tag;
        median_q.push_back(exp_r);
      end
      if (out_valid && out_ready) begin
        if (median_q.size() == 0) begin
          $display("%0t: unexpected item median=%0d dropped=%0b", $time, out_median,
                   out_dropped);
          errors++;
        end else begin
          exp_r = median_q.pop_front();
          if (out_median !== exp_r.median) begin
            $display("%0t: median expected %0d actual %0d", $time, exp_r.median, out_median);
            errors++;
          end
          if (out_dropped !== exp_r.dropped) begin
            $display("%0t: dropped expected %0b actual %0b", $time, exp_r.dropped,
                     out_dropped);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Drain and report
  initial begin
    wait (stim_done);
    wait (median_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && median_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
